### src/brbuf_pkg.sv
// shared types and constants of the circular byte buffer with search
package brbuf_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned DIST_W     = 4;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_POP   = 2'd1,
    OP_FIND  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_ACCEPT   = 2'd0,
    ST_REFUSE   = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NOTFOUND = 2'd3
  } st_e;

  typedef enum logic [2:0] {
    EMIT_NONE   = 3'd0,
    EMIT_WRITE  = 3'd1,
    EMIT_REFUSE = 3'd2,
    EMIT_POP    = 3'd3,
    EMIT_FIND   = 3'd4
  } emit_e;

  typedef struct packed {
    emit_e emit;
    logic  do_write;
    logic  idx_clr;
    logic  idx_inc;
    logic  rd_en;
    logic  pop_commit;
    logic  item_done;
    logic  find_set;
    logic  find_hit;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    op_e  opcode;
    logic out_free;
    logic pop_refuse;
    logic pop_zero;
    logic pop_last;
    logic occ_zero;
    logic find_match;
    logic find_end;
  } sts_t;

endpackage

### src/brbuf_ram.sv
// generic single write port ram with registered read
module brbuf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/brbuf_ctrl.sv
// control state machine sequencing writes, pop bursts and searches
module brbuf_ctrl import brbuf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_POP_RD   = 6'b000010,
    S_POP_OUT  = 6'b000100,
    S_FIND_RD  = 6'b001000,
    S_FIND_CMP = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    cmd.emit = EMIT_NONE;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (sts_i.item_valid) begin
          unique case (sts_i.opcode)
            OP_WRITE: begin
              if (sts_i.out_free) begin
                cmd.emit      = EMIT_WRITE;
                cmd.do_write  = 1'b1;
                cmd.item_done = 1'b1;
              end
            end
            OP_POP: begin
              priority if (sts_i.pop_refuse) begin
                if (sts_i.out_free) begin
                  cmd.emit      = EMIT_REFUSE;
                  cmd.item_done = 1'b1;
                end
              end else if (sts_i.pop_zero) begin
                cmd.item_done = 1'b1;
              end else begin
                cmd.idx_clr = 1'b1;
                state_d     = S_POP_RD;
              end
            end
            OP_FIND: begin
              if (sts_i.occ_zero) begin
                cmd.find_set = 1'b1;
                cmd.find_hit = 1'b0;
                state_d      = S_RESP;
              end else begin
                cmd.idx_clr = 1'b1;
                state_d     = S_FIND_RD;
              end
            end
            default: begin
              if (sts_i.out_free) begin
                cmd.emit      = EMIT_REFUSE;
                cmd.item_done = 1'b1;
              end
            end
          endcase
        end
      end
      S_POP_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (sts_i.out_free) begin
          cmd.emit = EMIT_POP;
          if (sts_i.pop_last) begin
            cmd.pop_commit = 1'b1;
            cmd.item_done  = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_d     = S_POP_RD;
          end
        end
      end
      S_FIND_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        priority if (sts_i.find_match) begin
          cmd.find_set = 1'b1;
          cmd.find_hit = 1'b1;
          state_d      = S_RESP;
        end else if (sts_i.find_end) begin
          cmd.find_set = 1'b1;
          cmd.find_hit = 1'b0;
          state_d      = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_FIND_RD;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd.emit      = EMIT_FIND;
          cmd.item_done = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

### src/brbuf_dp.sv
// datapath: input holding register, head and occupancy, byte store, output register
module brbuf_dp import brbuf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [AW-1:0] CAP = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic              item_valid_q, item_valid_d;
  op_e               item_op_q;
  logic [BYTE_W-1:0] item_byte_q;
  logic [CNT_W-1:0]  item_cnt_q;
  logic              item_first_q;

  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     occ_q, occ_d;
  logic              drop_q, drop_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              found_q;
  logic [DIST_W-1:0] dist_q;

  logic              out_valid_q, out_valid_d;
  st_e               out_st_q, out_st_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              out_last_q, out_last_d;

  logic [CW-1:0]     cnt_ext, occ_ext, idx_ext, free_ext;
  logic              fits, take, out_free, in_xfer;
  logic [AW-1:0]     waddr, raddr;
  logic [BYTE_W-1:0] rdata;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign cnt_ext  = CW'(item_cnt_q);
  assign occ_ext  = CW'(occ_q);
  assign idx_ext  = CW'(idx_q);
  assign free_ext = CW'(CAP - occ_q);

  assign fits = (cnt_ext <= free_ext);
  assign take = (item_first_q ? fits : !drop_q) && (occ_q != CAP);

  assign waddr = wrap_add(head_q, occ_q);
  assign raddr = wrap_add(head_q, idx_q);

  brbuf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_write && take),
    .waddr_i (waddr),
    .wdata_i (item_byte_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    item_valid_d = item_valid_q;
    if (cmd_i.item_done) begin
      item_valid_d = 1'b0;
    end else if (in_xfer) begin
      item_valid_d = 1'b1;
    end
  end

  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    drop_d = drop_q;
    idx_d  = idx_q;
    if (cmd_i.do_write) begin
      if (item_first_q) begin
        drop_d = !fits;
      end
      if (take) begin
        occ_d = occ_q + AW'(1);
      end
    end
    if (cmd_i.pop_commit) begin
      head_d = wrap_add(head_q, cnt_ext[AW-1:0]);
      occ_d  = occ_q - cnt_ext[AW-1:0];
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_comb begin
    out_st_d   = out_st_q;
    out_byte_d = out_byte_q;
    out_dist_d = out_dist_q;
    out_last_d = out_last_q;
    unique case (cmd_i.emit)
      EMIT_NONE: begin
      end
      EMIT_WRITE: begin
        out_st_d   = take ? ST_ACCEPT : ST_REFUSE;
        out_byte_d = '0;
        out_dist_d = '0;
        out_last_d = 1'b1;
      end
      EMIT_REFUSE: begin
        out_st_d   = ST_REFUSE;
        out_byte_d = '0;
        out_dist_d = '0;
        out_last_d = 1'b1;
      end
      EMIT_POP: begin
        out_st_d   = ST_ACCEPT;
        out_byte_d = rdata;
        out_dist_d = '0;
        out_last_d = sts_o.pop_last;
      end
      EMIT_FIND: begin
        out_st_d   = found_q ? ST_FOUND : ST_NOTFOUND;
        out_byte_d = '0;
        out_dist_d = dist_q;
        out_last_d = 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd_i.emit != EMIT_NONE) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      head_q       <= '0;
      occ_q        <= '0;
      drop_q       <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      head_q       <= head_d;
      occ_q        <= occ_d;
      drop_q       <= drop_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_op_q    <= op_e'(s_axis_tuser_i[OP_W-1:0]);
      item_first_q <= s_axis_tuser_i[OP_W];
      item_byte_q  <= s_axis_tdata_i[BYTE_W-1:0];
      item_cnt_q   <= s_axis_tdata_i[BYTE_W +: CNT_W];
    end
    if (cmd_i.find_set) begin
      found_q <= cmd_i.find_hit;
      dist_q  <= cmd_i.find_hit ? idx_ext[DIST_W-1:0] : '0;
    end
    out_st_q   <= out_st_d;
    out_byte_q <= out_byte_d;
    out_dist_q <= out_dist_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.item_valid = item_valid_q;
  assign sts_o.opcode     = item_op_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.pop_refuse = (cnt_ext > occ_ext);
  assign sts_o.pop_zero   = (item_cnt_q == '0);
  assign sts_o.pop_last   = ((idx_ext + CW'(1)) == cnt_ext);
  assign sts_o.occ_zero   = (occ_q == '0);
  assign sts_o.find_match = (rdata == item_byte_q);
  assign sts_o.find_end   = ((idx_q + AW'(1)) == occ_q);

  assign s_axis_tready_o = !item_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W-BYTE_W-DIST_W)'(0), out_dist_q, out_byte_q};
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### src/byte_ring_buffer_with_search_top.sv
// top level of the circular byte buffer with write, pop and find
// usage:
// - input stream: one item per transfer; tuser carries the opcode (write, pop,
//   find) and the first-byte-of-run flag, tdata the byte and the count
// - output stream: one result per item, one per byte for a pop and none for a pop
//   of zero bytes; tuser carries the status, tdata the popped byte and the search
//   distance, tlast marks the final result of an item
// - a write run is admitted or refused as a whole on its first byte
// - steps: a write or a refused op goes from the input register straight into the
//   output register; a pop passes a read state and an output state per byte, and a
//   find a read state and a compare state per occupied byte scanned, then a
//   response state, as the byte store has a single registered-read port
// - the input register takes the next item only once the held item is done
// - one item is held in an input register, so the next item is taken while
//   a result waits in the output register
// - receiver stall: the output register holds its result and work pauses;
//   input tready drops once an item is held
// - reset: head, occupancy and run state clear at once; the store contents
//   stay undefined, no clearing pass is needed
module byte_ring_buffer_with_search_top import brbuf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // byte_value, count, zero pad
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // opcode, first_in_run
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // byte_out, distance, zero pad
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,   // status
  output logic                  m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  brbuf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  brbuf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

### src/brbuf_chk.sv
// port-level checker of the circular byte buffer, bound to the top level
module brbuf_chk import brbuf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                  m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped without transfer");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is held");

  a_refuse_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_REFUSE) |-> m_axis_tlast_o)
    else $error("refusal not marked last");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_ACCEPT) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("byte set on a non-pop result");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_FOUND) |-> (m_axis_tdata_o[11:8] == 4'd0))
    else $error("distance set on a result that is not found");

endmodule

bind byte_ring_buffer_with_search_top brbuf_chk u_chk (.*);

### dv/tb_top.sv
// self-checking testbench of the circular byte buffer with write, pop and find
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brbuf_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned RAND_ITEMS  = 133;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    st_e               status;
    logic [BYTE_W-1:0] byte_out;
    logic [DIST_W-1:0] distance;
    logic              last;
  } resp_t;

  typedef struct {
    op_e               op;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              first;
    bit                fixed;
    st_e               fixed_st;
  } stim_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // byte_value, count, zero pad
  logic [IN_USER_W-1:0]  s_tuser = '0;   // opcode, first_in_run
  logic                  m_axis_tvalid_o;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o; // byte_out, distance, zero pad
  logic [OUT_USER_W-1:0] m_axis_tuser_o; // status
  logic                  m_axis_tlast_o;

  byte_ring_buffer_with_search_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the buffer
  logic [BYTE_W-1:0] mirror_mem [DEPTH];
  int unsigned       mirror_head = 0;
  int unsigned       mirror_occ = 0;
  bit                mirror_drop = 1'b0;

  resp_t       step_resp[$];
  resp_t       pending[$];
  stim_t       plan[$];
  int unsigned n_err = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  function automatic resp_t mk_resp(st_e st, logic [BYTE_W-1:0] b, logic [DIST_W-1:0] d,
                                    logic l);
    resp_t r;
    r.status   = st;
    r.byte_out = b;
    r.distance = d;
    r.last     = l;
    return r;
  endfunction

  // store position at an offset from the head
  function automatic logic [AW-1:0] slot(int unsigned off);
    return AW'((mirror_head + off) % DEPTH);
  endfunction

  function automatic void buffer_outcome(stim_t it);
    int unsigned cap;
    int unsigned i;
    bit          take;
    bit          hit;
    cap = DEPTH - 1;
    step_resp = {};
    case (it.op)
      OP_WRITE: begin
        if (it.first) begin
          mirror_drop = (it.count > cap - mirror_occ);
        end
        take = !mirror_drop;
        if (take && mirror_occ >= cap) take = 1'b0;
        if (take) begin
          mirror_mem[slot(mirror_occ)] = it.value;
          mirror_occ++;
          step_resp.push_back(mk_resp(ST_ACCEPT, '0, '0, 1'b1));
        end else begin
          step_resp.push_back(mk_resp(ST_REFUSE, '0, '0, 1'b1));
        end
      end
      OP_POP: begin
        if (it.count > mirror_occ) begin
          step_resp.push_back(mk_resp(ST_REFUSE, '0, '0, 1'b1));
        end else begin
          for (i = 0; i < it.count; i++) begin
            step_resp.push_back(mk_resp(ST_ACCEPT, mirror_mem[slot(i)], '0,
                                        (i + 1 == it.count)));
          end
          mirror_head = (mirror_head + it.count) % DEPTH;
          mirror_occ  = mirror_occ - it.count;
        end
      end
      OP_FIND: begin
        hit = 1'b0;
        for (i = 0; i < mirror_occ; i++) begin
          if (!hit && mirror_mem[slot(i)] == it.value) begin
            step_resp.push_back(mk_resp(ST_FOUND, '0, DIST_W'(i), 1'b1));
            hit = 1'b1;
          end
        end
        if (!hit) step_resp.push_back(mk_resp(ST_NOTFOUND, '0, '0, 1'b1));
      end
      default: begin
        step_resp.push_back(mk_resp(ST_REFUSE, '0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void add_row(op_e op, logic [BYTE_W-1:0] v, logic [CNT_W-1:0] c,
                                  logic f, bit fx, st_e st);
    stim_t r;
    r.op       = op;
    r.value    = v;
    r.count    = c;
    r.first    = f;
    r.fixed    = fx;
    r.fixed_st = st;
    plan.push_back(r);
  endfunction

  // entered and left at a falling edge
  task automatic issue(stim_t it);
    int unsigned gap;
    int unsigned k;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_tdata <= {{(IN_DATA_W - BYTE_W - CNT_W){1'b0}}, it.count, it.value};
    s_tuser <= {it.first, it.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    buffer_outcome(it);
    if (it.fixed) begin
      pending.push_back(mk_resp(it.fixed_st, '0, '0, 1'b1));
    end else begin
      for (k = 0; k < step_resp.size(); k++) pending.push_back(step_resp[k]);
    end
  endtask

  task automatic send(op_e op, logic [BYTE_W-1:0] v, logic [CNT_W-1:0] c, logic f);
    stim_t it;
    it.op       = op;
    it.value    = v;
    it.count    = c;
    it.first    = f;
    it.fixed    = 1'b0;
    it.fixed_st = ST_ACCEPT;
    issue(it);
  endtask

  // receiver stall pattern
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= (stall_left < 4);
    endcase
  end

  always @(posedge clk_i) begin : check_out
    resp_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending.size() == 0) begin
        $error("result transfer with nothing pending: status %0d", m_axis_tuser_o);
        n_err++;
      end else begin
        want = pending.pop_front();
        if (m_axis_tuser_o !== want.status) begin
          $error("status expected %0d got %0d", want.status, m_axis_tuser_o);
          n_err++;
        end
        if (m_axis_tdata_o[BYTE_W-1:0] !== want.byte_out) begin
          $error("byte_out expected %0h got %0h", want.byte_out, m_axis_tdata_o[BYTE_W-1:0]);
          n_err++;
        end
        if (m_axis_tdata_o[BYTE_W +: DIST_W] !== want.distance) begin
          $error("distance expected %0d got %0d", want.distance,
                 m_axis_tdata_o[BYTE_W +: DIST_W]);
          n_err++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last expected %0d got %0d", want.last, m_axis_tlast_o);
          n_err++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned k;
    int unsigned rand_count;
    int unsigned pick;
    int unsigned free;
    int unsigned len;
    int unsigned sel;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] val;

    // directed rows
    add_row(OP_POP,   8'h00, 4'd1,  1'b0, 1'b1, ST_REFUSE);
    add_row(OP_FIND,  8'h00, 4'd0,  1'b0, 1'b1, ST_NOTFOUND);
    add_row(OP_RSVD,  8'hff, 4'd15, 1'b1, 1'b1, ST_REFUSE);
    add_row(OP_POP,   8'h00, 4'd0,  1'b0, 1'b0, ST_ACCEPT);
    add_row(OP_WRITE, 8'h00, 4'd3,  1'b1, 1'b0, ST_ACCEPT);
    add_row(OP_WRITE, 8'hff, 4'd3,  1'b0, 1'b0, ST_ACCEPT);
    add_row(OP_WRITE, 8'h80, 4'd3,  1'b0, 1'b0, ST_ACCEPT);
    add_row(OP_FIND,  8'hff, 4'd0,  1'b0, 1'b0, ST_ACCEPT);
    add_row(OP_FIND,  8'h11, 4'd0,  1'b0, 1'b0, ST_ACCEPT);
    // run too long for the free space, then its tail
    add_row(OP_WRITE, 8'haa, 4'd13, 1'b1, 1'b1, ST_REFUSE);
    add_row(OP_WRITE, 8'hbb, 4'd13, 1'b0, 1'b1, ST_REFUSE);
    // fill to capacity
    for (i = 0; i < 12; i++) begin
      add_row(OP_WRITE, 8'(1 + 23 * i), 4'd12, (i == 0), 1'b0, ST_ACCEPT);
    end
    add_row(OP_WRITE, 8'h55, 4'd0,  1'b0, 1'b1, ST_REFUSE);
    add_row(OP_FIND,  8'hfe, 4'd0,  1'b0, 1'b0, ST_ACCEPT);
    add_row(OP_POP,   8'h00, 4'd15, 1'b0, 1'b0, ST_ACCEPT);
    add_row(OP_POP,   8'h00, 4'd1,  1'b0, 1'b1, ST_REFUSE);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < plan.size(); i++) issue(plan[i]);

    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      gaps_on = ((rand_count / 40) % 3) != 1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        free = DEPTH - 1 - mirror_occ;
        if (free != 0 && $urandom_range(0, 3) != 0) cnt = CNT_W'($urandom_range(1, free));
        else cnt = CNT_W'($urandom_range(0, 15));
        len = cnt;
        sel = $urandom_range(0, 9);
        if (sel == 0) len = cnt + $urandom_range(1, 3);
        else if (sel == 1 && cnt > 1) len = cnt - 1;
        if (len == 0) len = 1;
        for (k = 0; k < len; k++) begin
          send(OP_WRITE, BYTE_W'($urandom_range(0, 255)), cnt, (k == 0));
          rand_count++;
        end
      end else if (pick < 70) begin
        if (mirror_occ != 0 && $urandom_range(0, 4) != 0) begin
          cnt = CNT_W'($urandom_range(0, mirror_occ));
        end else begin
          cnt = CNT_W'($urandom_range(0, 15));
        end
        send(OP_POP, BYTE_W'($urandom_range(0, 255)), cnt, 1'($urandom_range(0, 1)));
        rand_count++;
      end else if (pick < 90) begin
        if (mirror_occ != 0 && $urandom_range(0, 9) < 7) begin
          val = mirror_mem[slot($urandom_range(0, mirror_occ - 1))];
        end else begin
          val = BYTE_W'($urandom_range(0, 255));
        end
        send(OP_FIND, val, CNT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        rand_count++;
      end else begin
        if ($urandom_range(0, 1) != 0) begin
          send(OP_RSVD, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)));
        end else begin
          send(OP_WRITE, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 15)),
               1'b0);
        end
        rand_count++;
      end
    end
    s_valid <= 1'b0;

    while (pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_err == 0 && pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
